// ===== design/ptsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-triangle squared distance package
// Shared widths, request and result types, and the queue entry format.
// ----------------------------------------------------------------------------
package ptsd_pkg;

  // Field widths and the number of coordinate bits that are used.
  localparam int CoordW    = 16;
  localparam int CoordBits = 16;
  localparam int SqW       = 42;
  localparam int SqFrac    = 8;
  localparam int ParFrac   = 16;
  localparam int ParW      = ParFrac + 1;

  // Internal arithmetic widths, derived from the coordinate bits used and, for the numerator, SqFrac.
  localparam int DiffW  = CoordBits + 1;
  localparam int DotW   = 2 * DiffW + 2;
  localparam int ProdW  = 2 * DotW;
  localparam int NumW   = ProdW + 1;
  localparam int SmW    = DotW + 3;
  localparam int MulW   = ProdW + 1 + DiffW;
  localparam int VW     = MulW + 2;
  localparam int V2W    = 2 * VW;
  localparam int SumW   = V2W + 2;
  localparam int D2W    = 2 * ProdW;
  localparam int DivW   = D2W + 1;
  localparam int NumerW = SumW + SqFrac + 2;

  // Limb split used by the wide squarers in the back end.
  localparam int LimbW  = 32;
  localparam int SqInW  = 3 * LimbW;
  localparam int SqOutW = 2 * SqInW;

  // Pipeline depths and queue size.
  localparam int FrontStages = 5;
  localparam int BackStages  = 6;
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  typedef struct packed {
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic [CoordW-1:0] point_z;
    logic [CoordW-1:0] vertex_a_x;
    logic [CoordW-1:0] vertex_a_y;
    logic [CoordW-1:0] vertex_a_z;
    logic [CoordW-1:0] vertex_b_x;
    logic [CoordW-1:0] vertex_b_y;
    logic [CoordW-1:0] vertex_b_z;
    logic [CoordW-1:0] vertex_c_x;
    logic [CoordW-1:0] vertex_c_y;
    logic [CoordW-1:0] vertex_c_z;
  } req_t;

  typedef struct packed {
    logic [SqW-1:0]  sq_distance;
    logic [ParW-1:0] param_s;
    logic [ParW-1:0] param_t;
    logic [ParW-1:0] weight_first;
    logic            degenerate;
  } res_t;

  // Offset to the first vertex and the edge vectors e0 and e1.
  typedef struct packed {
    logic [2:0][DiffW-1:0] d;
    logic [2:0][DiffW-1:0] e0;
    logic [2:0][DiffW-1:0] e1;
  } geom_t;

  // Classified request: s = sn / dd and t = tn / dd.
  typedef struct packed {
    geom_t           geom;
    logic [ProdW-1:0] sn;
    logic [ProdW-1:0] tn;
    logic [ProdW-1:0] dd;
    logic             degen;
  } job_t;

  // Queue status towards the top level.
  typedef struct packed {
    logic full;
    logic pop;
  } qstat_t;

endpackage

// ===== design/point_triangle_squared_distance_core.sv =====
// ----------------------------------------------------------------------------
// Point-triangle squared distance core
// Throughput: one request per cycle while busy is low, set by the fully pipelined front end,
// back end and one-bit-per-stage divider (42 stages for the distance).
// busy stays low in normal use, as the back end drains the queue each cycle.
// Reset clears all valid bits and the queue; results carry no reset.
// ----------------------------------------------------------------------------
module point_triangle_squared_distance_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ptsd_pkg::req_t  req_i,
  output logic            res_valid_o,
  output ptsd_pkg::res_t  res_o
);
  import ptsd_pkg::*;

  localparam int LatCycles = FrontStages + 1 + BackStages + SqW + 1;

  logic   accept, push;
  job_t   front_job, queue_job;
  qstat_t qstat;

  // A request is taken when the queue has room.
  assign busy   = qstat.full;
  assign accept = start && !busy;

  ptsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .push_o   (push),
    .job_o    (front_job)
  );

  ptsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .stat_o (qstat),
    .job_o  (queue_job)
  );

  ptsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (qstat.pop),
    .job_i       (queue_job),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Every accepted request gives its result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##LatCycles res_valid_o)
    else $error("result missing after the pipeline latency");

  // A degenerate result carries zero parameters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_valid_o && res_o.degenerate |->
                   res_o.param_s == '0 && res_o.param_t == '0)
    else $error("degenerate result with nonzero parameters");

endmodule

// ===== design/ptsd_front.sv =====
// ----------------------------------------------------------------------------
// Point-triangle front end
// Forms the edge vectors, dot products and determinant, and picks the region
// of the closest point as a rational pair of parameters.
// ----------------------------------------------------------------------------
module ptsd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  ptsd_pkg::req_t  req_i,
  output logic            push_o,
  output ptsd_pkg::job_t  job_o
);
  import ptsd_pkg::*;

  localparam int RegW = NumW + 2;

  typedef struct packed {
    logic [ProdW-1:0] num;
    logic [ProdW-1:0] den;
  } edge_t;

  typedef struct packed {
    logic [DotW-1:0] a00;
    logic [DotW-1:0] a01;
    logic [DotW-1:0] a11;
    logic [DotW-1:0] b0;
    logic [DotW-1:0] b1;
  } dots_t;

  function automatic logic signed [DiffW-1:0] cx(logic [CoordW-1:0] v);
    return DiffW'($signed(v[CoordBits-1:0]));
  endfunction

  function automatic logic signed [DotW-1:0] dmul(logic [DiffW-1:0] x, logic [DiffW-1:0] y);
    return DotW'($signed(x)) * DotW'($signed(y));
  endfunction

  function automatic logic signed [ProdW-1:0] pmul(logic [DotW-1:0] x, logic [DotW-1:0] y);
    return ProdW'($signed(x)) * ProdW'($signed(y));
  endfunction

  // Edge parameter: zero end first, then the far end, else the ratio.
  function automatic edge_t edge_std(logic signed [DotW-1:0] b, logic signed [DotW-1:0] a);
    edge_t r;
    logic signed [DotW:0] nb;
    nb    = -((DotW+1)'(b));
    r.num = '0;
    r.den = ProdW'(1);
    if (!b[DotW-1]) begin
      r.num = '0;
    end else if (nb >= (DotW+1)'(a)) begin
      r.num = ProdW'(1);
    end else begin
      r.num = ProdW'(nb);
      r.den = ProdW'(a);
    end
    return r;
  endfunction

  // Edge parameter with the far end tested first.
  function automatic edge_t edge_onefirst(logic signed [DotW-1:0] b,
                                          logic signed [DotW-1:0] a);
    edge_t r;
    logic signed [DotW:0] nb;
    logic signed [DotW:0] ab;
    nb    = -((DotW+1)'(b));
    ab    = (DotW+1)'(a) + (DotW+1)'(b);
    r.num = '0;
    r.den = ProdW'(1);
    if (ab <= 0) begin
      r.num = ProdW'(1);
    end else if (!b[DotW-1]) begin
      r.num = '0;
    end else begin
      r.num = ProdW'(nb);
      r.den = ProdW'(a);
    end
    return r;
  endfunction

  logic [FrontStages-1:0] vld_q;
  req_t  in_q;
  geom_t g2_q, g3_q, g4_q, g5_q, g2_d;
  dots_t dt3_q, dt4_q, dt5_q, dt3_d;
  logic signed [ProdW-1:0] p00_11_q, p01_01_q, p01_b1_q, p11_b0_q, p01_b0_q, p00_b1_q;
  logic signed [NumW-1:0]  det_q, snum_q, tnum_q;
  logic signed [SmW-1:0]   den_q, nu_q;

  // Valid bits of the front pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FrontStages-2:0], accept_i};
    end
  end

  // Differences to the first vertex.
  always_comb begin
    g2_d.d[0]  = cx(in_q.vertex_a_x) - cx(in_q.point_x);
    g2_d.d[1]  = cx(in_q.vertex_a_y) - cx(in_q.point_y);
    g2_d.d[2]  = cx(in_q.vertex_a_z) - cx(in_q.point_z);
    g2_d.e0[0] = cx(in_q.vertex_b_x) - cx(in_q.vertex_a_x);
    g2_d.e0[1] = cx(in_q.vertex_b_y) - cx(in_q.vertex_a_y);
    g2_d.e0[2] = cx(in_q.vertex_b_z) - cx(in_q.vertex_a_z);
    g2_d.e1[0] = cx(in_q.vertex_c_x) - cx(in_q.vertex_a_x);
    g2_d.e1[1] = cx(in_q.vertex_c_y) - cx(in_q.vertex_a_y);
    g2_d.e1[2] = cx(in_q.vertex_c_z) - cx(in_q.vertex_a_z);
  end

  // Dot products of the edges and the offset.
  always_comb begin
    dt3_d.a00 = dmul(g2_q.e0[0], g2_q.e0[0]) + dmul(g2_q.e0[1], g2_q.e0[1])
              + dmul(g2_q.e0[2], g2_q.e0[2]);
    dt3_d.a01 = dmul(g2_q.e0[0], g2_q.e1[0]) + dmul(g2_q.e0[1], g2_q.e1[1])
              + dmul(g2_q.e0[2], g2_q.e1[2]);
    dt3_d.a11 = dmul(g2_q.e1[0], g2_q.e1[0]) + dmul(g2_q.e1[1], g2_q.e1[1])
              + dmul(g2_q.e1[2], g2_q.e1[2]);
    dt3_d.b0  = dmul(g2_q.d[0], g2_q.e0[0]) + dmul(g2_q.d[1], g2_q.e0[1])
              + dmul(g2_q.d[2], g2_q.e0[2]);
    dt3_d.b1  = dmul(g2_q.d[0], g2_q.e1[0]) + dmul(g2_q.d[1], g2_q.e1[1])
              + dmul(g2_q.d[2], g2_q.e1[2]);
  end

  // Payload stages: input, differences, dots, products, determinant.
  always_ff @(posedge clk_i) begin
    in_q     <= req_i;
    g2_q     <= g2_d;
    g3_q     <= g2_q;
    dt3_q    <= dt3_d;
    g4_q     <= g3_q;
    dt4_q    <= dt3_q;
    p00_11_q <= pmul(dt3_q.a00, dt3_q.a11);
    p01_01_q <= pmul(dt3_q.a01, dt3_q.a01);
    p01_b1_q <= pmul(dt3_q.a01, dt3_q.b1);
    p11_b0_q <= pmul(dt3_q.a11, dt3_q.b0);
    p01_b0_q <= pmul(dt3_q.a01, dt3_q.b0);
    p00_b1_q <= pmul(dt3_q.a00, dt3_q.b1);
    g5_q     <= g4_q;
    dt5_q    <= dt4_q;
    det_q    <= NumW'(p00_11_q) - NumW'(p01_01_q);
    snum_q   <= NumW'(p01_b1_q) - NumW'(p11_b0_q);
    tnum_q   <= NumW'(p01_b0_q) - NumW'(p00_b1_q);
    den_q    <= SmW'($signed(dt4_q.a00)) - (SmW'($signed(dt4_q.a01)) <<< 1)
              + SmW'($signed(dt4_q.a11));
    nu_q     <= SmW'($signed(dt4_q.a11)) + SmW'($signed(dt4_q.b1))
              - SmW'($signed(dt4_q.a01)) - SmW'($signed(dt4_q.b0));
  end

  // Region test and choice of the closest-point parameters.
  logic signed [RegW-1:0] rt;
  logic signed [SmW-1:0]  nun;
  logic                   s_neg, t_neg;
  edge_t                  ed;

  always_comb begin
    rt    = RegW'(det_q) - RegW'(snum_q) - RegW'(tnum_q);
    // Numerator along the edge from the second vertex towards the third.
    nun   = den_q - nu_q;
    s_neg = snum_q[NumW-1];
    t_neg = tnum_q[NumW-1];
    ed    = '0;
    job_o.geom  = g5_q;
    job_o.sn    = '0;
    job_o.tn    = '0;
    job_o.dd    = ProdW'(1);
    job_o.degen = 1'b0;
    if (!rt[RegW-1]) begin
      if (s_neg) begin
        if (t_neg && dt5_q.b0[DotW-1]) begin
          ed       = edge_std($signed(dt5_q.b0), $signed(dt5_q.a00));
          job_o.sn = ed.num;
          job_o.dd = ed.den;
        end else begin
          ed       = edge_std($signed(dt5_q.b1), $signed(dt5_q.a11));
          job_o.tn = ed.num;
          job_o.dd = ed.den;
        end
      end else if (t_neg) begin
        ed       = edge_std($signed(dt5_q.b0), $signed(dt5_q.a00));
        job_o.sn = ed.num;
        job_o.dd = ed.den;
      end else if (det_q == '0) begin
        job_o.degen = 1'b1;
      end else begin
        job_o.sn = ProdW'(snum_q);
        job_o.tn = ProdW'(tnum_q);
        job_o.dd = ProdW'(det_q);
      end
    end else begin
      if (s_neg) begin
        if (nu_q > 0) begin
          if (nu_q >= den_q) begin
            job_o.sn = ProdW'(1);
          end else begin
            job_o.sn = ProdW'(nu_q);
            job_o.tn = ProdW'(den_q - nu_q);
            job_o.dd = ProdW'(den_q);
          end
        end else begin
          ed       = edge_onefirst($signed(dt5_q.b1), $signed(dt5_q.a11));
          job_o.tn = ed.num;
          job_o.dd = ed.den;
        end
      end else if (t_neg) begin
        if (nun > 0) begin
          if (nun >= den_q) begin
            job_o.tn = ProdW'(1);
          end else begin
            job_o.tn = ProdW'(nun);
            job_o.sn = ProdW'(den_q - nun);
            job_o.dd = ProdW'(den_q);
          end
        end else begin
          ed       = edge_onefirst($signed(dt5_q.b0), $signed(dt5_q.a00));
          job_o.sn = ed.num;
          job_o.dd = ed.den;
        end
      end else begin
        if (nu_q <= 0) begin
          job_o.tn = ProdW'(1);
        end else if (nu_q >= den_q) begin
          job_o.sn = ProdW'(1);
        end else begin
          job_o.sn = ProdW'(nu_q);
          job_o.tn = ProdW'(den_q - nu_q);
          job_o.dd = ProdW'(den_q);
        end
      end
    end
  end

  assign push_o = vld_q[FrontStages-1];

endmodule

// ===== design/ptsd_queue.sv =====
// ----------------------------------------------------------------------------
// Point-triangle request queue
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ptsd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ptsd_pkg::job_t    job_i,
  output ptsd_pkg::qstat_t  stat_o,
  output ptsd_pkg::job_t    job_o
);
  import ptsd_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;

  // The back end takes an entry whenever one is waiting.
  assign pop          = (cnt_q != '0);
  assign stat_o.pop   = pop;
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign job_o        = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // A request never arrives at a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !stat_o.full)
    else $error("request pushed into a full queue");

  // The fill count stays within the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("queue fill count out of range");

endmodule

// ===== design/ptsd_div.sv =====
// ----------------------------------------------------------------------------
// Point-triangle pipelined divider
// Restoring division, one quotient bit per stage, for the rounded squared
// distance and the two barycentric parameters.
// ----------------------------------------------------------------------------
module ptsd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ptsd_pkg::SumW-1:0]    sum_i,
  input  logic [ptsd_pkg::D2W-1:0]     d2_i,
  input  logic [ptsd_pkg::ProdW-1:0]   sn_i,
  input  logic [ptsd_pkg::ProdW-1:0]   tn_i,
  input  logic [ptsd_pkg::ProdW-1:0]   dd_i,
  input  logic                         degen_i,
  output logic                         valid_o,
  output logic [ptsd_pkg::SqW-1:0]     q_sq_o,
  output logic [ptsd_pkg::ParW-1:0]    q_s_o,
  output logic [ptsd_pkg::ParW-1:0]    q_t_o,
  output logic                         degen_o
);
  import ptsd_pkg::*;

  typedef struct packed {
    logic [DivW-1:0]  den_sq;
    logic [DivW-1:0]  rem_sq;
    logic [SqW-1:0]   low_sq;
    logic [SqW-1:0]   q_sq;
    logic [ProdW-1:0] den_p;
    logic [ProdW-1:0] rem_s;
    logic [ProdW-1:0] rem_t;
    logic [ParW-1:0]  low_s;
    logic [ParW-1:0]  low_t;
    logic [ParW-1:0]  q_s;
    logic [ParW-1:0]  q_t;
    logic             degen;
  } stage_t;

  // One step of each division; the parameter divisions stop early.
  function automatic stage_t step(stage_t s, logic do_par);
    stage_t        n;
    logic [DivW:0]  r2;
    logic [ProdW:0] rs;
    logic [ProdW:0] rt;
    n  = s;
    r2 = {s.rem_sq, s.low_sq[SqW-1]};
    n.low_sq = s.low_sq << 1;
    if (r2 >= {1'b0, s.den_sq}) begin
      n.rem_sq = DivW'(r2 - {1'b0, s.den_sq});
      n.q_sq   = {s.q_sq[SqW-2:0], 1'b1};
    end else begin
      n.rem_sq = r2[DivW-1:0];
      n.q_sq   = {s.q_sq[SqW-2:0], 1'b0};
    end
    if (do_par) begin
      rs = {s.rem_s, s.low_s[ParW-1]};
      rt = {s.rem_t, s.low_t[ParW-1]};
      n.low_s = s.low_s << 1;
      n.low_t = s.low_t << 1;
      if (rs >= {1'b0, s.den_p}) begin
        n.rem_s = ProdW'(rs - {1'b0, s.den_p});
        n.q_s   = {s.q_s[ParW-2:0], 1'b1};
      end else begin
        n.rem_s = rs[ProdW-1:0];
        n.q_s   = {s.q_s[ParW-2:0], 1'b0};
      end
      if (rt >= {1'b0, s.den_p}) begin
        n.rem_t = ProdW'(rt - {1'b0, s.den_p});
        n.q_t   = {s.q_t[ParW-2:0], 1'b1};
      end else begin
        n.rem_t = rt[ProdW-1:0];
        n.q_t   = {s.q_t[ParW-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  stage_t            st_q [SqW+1];
  stage_t            init;
  logic [SqW:0]      vld_q;
  logic [NumerW-1:0] numer;

  // Rounded squared distance: (512 * sum + d2) / (2 * d2).
  always_comb begin
    numer       = NumerW'({sum_i, (SqFrac+1)'(0)}) + NumerW'(d2_i);
    init.den_sq = {d2_i, 1'b0};
    init.rem_sq = numer[SqW +: DivW];
    init.low_sq = numer[SqW-1:0];
    init.q_sq   = '0;
    init.den_p  = dd_i;
    init.rem_s  = sn_i >> 1;
    init.rem_t  = tn_i >> 1;
    init.low_s  = {sn_i[0], ParFrac'(0)};
    init.low_t  = {tn_i[0], ParFrac'(0)};
    init.q_s    = '0;
    init.q_t    = '0;
    init.degen  = degen_i;
  end

  // Valid bits of the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SqW-1:0], valid_i};
    end
  end

  // Divider stages.
  always_ff @(posedge clk_i) begin
    st_q[0] <= init;
    for (int j = 0; j < SqW; j++) begin
      st_q[j+1] <= step(st_q[j], j < ParW);
    end
  end

  assign valid_o = vld_q[SqW];
  assign q_sq_o  = st_q[SqW].q_sq;
  assign q_s_o   = st_q[SqW].q_s;
  assign q_t_o   = st_q[SqW].q_t;
  assign degen_o = st_q[SqW].degen;

endmodule

// ===== design/ptsd_back.sv =====
// ----------------------------------------------------------------------------
// Point-triangle back end
// Forms the scaled offset to the closest point, its squared length, and
// hands the division operands to the divider; registers the result.
// ----------------------------------------------------------------------------
module ptsd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_i,
  input  ptsd_pkg::job_t  job_i,
  output logic            res_valid_o,
  output ptsd_pkg::res_t  res_o
);
  import ptsd_pkg::*;

  typedef struct packed {
    logic [ProdW-1:0] sn;
    logic [ProdW-1:0] tn;
    logic [ProdW-1:0] dd;
    logic             degen;
  } carry_t;

  // Limb products of a square: three limbs give six distinct products.
  typedef struct packed {
    logic [2*LimbW-1:0] p00;
    logic [2*LimbW-1:0] p11;
    logic [2*LimbW-1:0] p22;
    logic [2*LimbW-1:0] p01;
    logic [2*LimbW-1:0] p02;
    logic [2*LimbW-1:0] p12;
  } sqpp_t;

  function automatic logic signed [MulW-1:0] mmul(logic [ProdW-1:0] u, logic [DiffW-1:0] s);
    return MulW'($signed({1'b0, u})) * MulW'($signed(s));
  endfunction

  function automatic sqpp_t sq_split(logic [SqInW-1:0] x);
    sqpp_t r;
    r.p00 = (2*LimbW)'(x[0 +: LimbW]) * (2*LimbW)'(x[0 +: LimbW]);
    r.p11 = (2*LimbW)'(x[LimbW +: LimbW]) * (2*LimbW)'(x[LimbW +: LimbW]);
    r.p22 = (2*LimbW)'(x[2*LimbW +: LimbW]) * (2*LimbW)'(x[2*LimbW +: LimbW]);
    r.p01 = (2*LimbW)'(x[0 +: LimbW]) * (2*LimbW)'(x[LimbW +: LimbW]);
    r.p02 = (2*LimbW)'(x[0 +: LimbW]) * (2*LimbW)'(x[2*LimbW +: LimbW]);
    r.p12 = (2*LimbW)'(x[LimbW +: LimbW]) * (2*LimbW)'(x[2*LimbW +: LimbW]);
    return r;
  endfunction

  // Cross products count twice, hence the extra shift by one.
  function automatic logic [SqOutW-1:0] sq_join(sqpp_t p);
    return SqOutW'(p.p00) + (SqOutW'(p.p01) << (LimbW + 1))
         + (SqOutW'(p.p11) << (2 * LimbW)) + (SqOutW'(p.p02) << (2 * LimbW + 1))
         + (SqOutW'(p.p12) << (3 * LimbW + 1)) + (SqOutW'(p.p22) << (4 * LimbW));
  endfunction

  logic [4:0]              vld_q;
  carry_t                  c1_q, c2_q, c3_q, c4_q, c5_q;
  sqpp_t                   ddp_q;
  logic [D2W-1:0]          d22_q, d23_q, d24_q, d25_q;
  logic signed [MulW-1:0]  pd_q [3];
  logic signed [MulW-1:0]  ps_q [3];
  logic signed [MulW-1:0]  pt_q [3];
  logic signed [VW-1:0]    vs [3];
  logic [VW-1:0]           v_q [3];
  sqpp_t                   vp_q [3];
  logic [V2W-1:0]          vv_q [3];
  logic [SumW-1:0]         sum_q;
  logic                    div_valid, div_degen;
  logic [SqW-1:0]          q_sq;
  logic [ParW-1:0]         q_s, q_t;

  // Valid bits of the back pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      vld_q       <= {vld_q[3:0], pop_i};
      res_valid_o <= div_valid;
    end
  end

  // Scaled offset per axis; only its magnitude is needed for the square.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vs[k] = VW'(pd_q[k]) + VW'(ps_q[k]) + VW'(pt_q[k]);
    end
  end

  // Products, offset magnitude, limb products, squares and their total.
  always_ff @(posedge clk_i) begin
    c1_q  <= '{sn: job_i.sn, tn: job_i.tn, dd: job_i.dd, degen: job_i.degen};
    ddp_q <= sq_split(SqInW'(job_i.dd));
    for (int k = 0; k < 3; k++) begin
      pd_q[k] <= mmul(job_i.dd, job_i.geom.d[k]);
      ps_q[k] <= mmul(job_i.sn, job_i.geom.e0[k]);
      pt_q[k] <= mmul(job_i.tn, job_i.geom.e1[k]);
    end
    c2_q  <= c1_q;
    d22_q <= D2W'(sq_join(ddp_q));
    for (int k = 0; k < 3; k++) begin
      v_q[k] <= vs[k][VW-1] ? $unsigned(-vs[k]) : $unsigned(vs[k]);
    end
    c3_q  <= c2_q;
    d23_q <= d22_q;
    for (int k = 0; k < 3; k++) begin
      vp_q[k] <= sq_split(SqInW'(v_q[k]));
    end
    c4_q  <= c3_q;
    d24_q <= d23_q;
    for (int k = 0; k < 3; k++) begin
      vv_q[k] <= V2W'(sq_join(vp_q[k]));
    end
    c5_q  <= c4_q;
    d25_q <= d24_q;
    sum_q <= SumW'(vv_q[0]) + SumW'(vv_q[1]) + SumW'(vv_q[2]);
  end

  ptsd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[4]),
    .sum_i   (sum_q),
    .d2_i    (d25_q),
    .sn_i    (c5_q.sn),
    .tn_i    (c5_q.tn),
    .dd_i    (c5_q.dd),
    .degen_i (c5_q.degen),
    .valid_o (div_valid),
    .q_sq_o  (q_sq),
    .q_s_o   (q_s),
    .q_t_o   (q_t),
    .degen_o (div_degen)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    res_o.sq_distance  <= q_sq;
    res_o.param_s      <= q_s;
    res_o.param_t      <= q_t;
    res_o.weight_first <= ParW'(1 << ParFrac) - q_s - q_t;
    res_o.degenerate   <= div_degen;
  end

endmodule
